// ===== hdl/mirrored_line_fir_sym_antisym_unit_assert.svh =====
// Assertion macros for the mirrored line filter
`ifndef MIRRORED_LINE_FIR_SYM_ANTISYM_UNIT_ASSERT_SVH
`define MIRRORED_LINE_FIR_SYM_ANTISYM_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define MLF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlf: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define MLF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlf: next-cycle check failed");
`else
`define MLF_ASSERT_IMP(lbl, ante, cons)
`define MLF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mlf_pkg.sv =====
// Shared types and constants of the mirrored line filter
package mlf_pkg;

	// coefficient field width (signed Q1.x)
	localparam int COEF_W = 16;

	// configuration port geometry
	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	// register reset values
	localparam logic [APB_DW-1:0] COEF_LOW_RST  = 64'd16384;
	localparam logic [APB_DW-1:0] COEF_HIGH_RST = 64'd0;
	localparam logic [2:0]        RADIUS_RST    = 3'd1;

	// register indexes
	typedef enum logic [1:0] {
		REG_COEF_LOW  = 2'd0,
		REG_COEF_HIGH = 2'd1,
		REG_RADIUS    = 2'd2,
		REG_ANTISYM   = 2'd3
	} reg_idx_t;

	// flags that ride along with a job through the datapath
	typedef struct packed {
		logic last;
		logic line_short;
	} job_flags_t;

endpackage

// ===== hdl/mlf_stream_if.sv =====
// Stream interfaces for sample items and result items
interface mlf_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           last_in_line;

	modport source (output valid, output sample, output last_in_line, input ready);
	modport sink (input valid, input sample, input last_in_line, output ready);
endinterface

interface mlf_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] filtered;
	logic                           last_of_line;
	logic                           clipped;
	logic                           line_too_short;

	modport source (output valid, output filtered, output last_of_line, output clipped,
		output line_too_short, input ready);
	modport sink (input valid, input filtered, input last_of_line, input clipped,
		input line_too_short, output ready);
endinterface

// ===== hdl/mlf_cfg_regs.sv =====
// APB register file: coefficients, radius and mode
module mlf_cfg_regs import mlf_pkg::*; #(
	parameter int MAX_RADIUS = 7,
	localparam int M_W = $clog2(MAX_RADIUS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	output logic signed [COEF_W-1:0] coef [MAX_RADIUS+1],
	output logic [M_W-1:0]           rad,
	output logic                     antisym
);

	logic [APB_DW-1:0]   coef_low_q;
	logic [APB_DW-1:0]   coef_high_q;
	logic [2:0]          radius_q;
	logic                antisym_q;
	logic                wr_en;
	reg_idx_t            idx;
	logic [2*APB_DW-1:0] coef_all;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:3]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_low_q  <= COEF_LOW_RST;
			coef_high_q <= COEF_HIGH_RST;
			radius_q    <= RADIUS_RST;
			antisym_q   <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_COEF_LOW:  coef_low_q  <= pwdata;
				REG_COEF_HIGH: coef_high_q <= pwdata;
				REG_RADIUS:    radius_q    <= pwdata[2:0];
				REG_ANTISYM:   antisym_q   <= pwdata[0];
				default:       coef_low_q  <= coef_low_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_COEF_LOW:  prdata = coef_low_q;
			REG_COEF_HIGH: prdata = coef_high_q;
			REG_RADIUS:    prdata = APB_DW'(radius_q);
			REG_ANTISYM:   prdata = APB_DW'(antisym_q);
			default:       prdata = '0;
		endcase
	end

	// coefficient unpack, c0 in the lowest bits
	assign coef_all = {coef_high_q, coef_low_q};
	for (genvar p = 0; p <= MAX_RADIUS; p++) begin : g_coef
		assign coef[p] = $signed(coef_all[COEF_W*p +: COEF_W]);
	end

	// radius limited to what the window supports
	assign rad = (radius_q > MAX_RADIUS) ? M_W'(MAX_RADIUS) : M_W'(radius_q);
	assign antisym = antisym_q;

endmodule

// ===== hdl/mlf_window.sv =====
// Sample window, line counter and output-position sequencer
module mlf_window import mlf_pkg::*; #(
	parameter int MAX_RADIUS   = 7,
	parameter int SAMPLE_WIDTH = 16,
	localparam int WIN   = 2 * MAX_RADIUS + 1,
	localparam int M_W   = $clog2(MAX_RADIUS + 1),
	localparam int CNT_W = $clog2(WIN + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mlf_in_if.sink                         samples,
	input  logic [M_W-1:0]                 rad,
	output logic signed [SAMPLE_WIDTH-1:0] win [WIN],
	output logic                           job_vld,
	input  logic                           job_rdy,
	output logic [M_W-1:0]                 job_m,
	output logic [CNT_W-1:0]               job_c,
	output job_flags_t                     job_flags
);

	logic signed [SAMPLE_WIDTH-1:0] win_q [WIN];
	logic [CNT_W-1:0] seen_q;
	logic             job_vld_q;
	logic [M_W-1:0]   job_m_q;
	logic [CNT_W-1:0] job_c_q;
	logic             job_flush_q;
	logic             job_short_q;
	logic             take;
	logic             more_flush;
	logic [CNT_W-1:0] c_new;
	logic [CNT_W-1:0] cm1;
	logic [CNT_W-1:0] rad_c;
	logic [M_W-1:0]   m_flush;

	// a line end drains one position per cycle while the fetch stage is ready; input waits until the last one
	assign more_flush    = job_flush_q && (job_m_q != '0);
	assign samples.ready = !job_vld_q || (job_rdy && !more_flush);
	assign take          = samples.valid && samples.ready;

	// count of held samples after this one, saturating at the window depth
	assign c_new   = (seen_q == CNT_W'(WIN)) ? seen_q : seen_q + CNT_W'(1);
	assign cm1     = c_new - CNT_W'(1);
	assign rad_c   = CNT_W'(rad);
	assign m_flush = (cm1 < rad_c) ? cm1[M_W-1:0] : rad;

	// window shift, newest first
	always_ff @(posedge clk) begin
		if (take) begin
			win_q[0] <= samples.sample;
			for (int i = 1; i < WIN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	// line count and job sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			job_vld_q   <= 1'b0;
			job_m_q     <= '0;
			job_c_q     <= '0;
			job_flush_q <= 1'b0;
			job_short_q <= 1'b0;
		end else if (take) begin
			seen_q      <= samples.last_in_line ? '0 : c_new;
			job_vld_q   <= samples.last_in_line || (c_new > rad_c);
			job_m_q     <= samples.last_in_line ? m_flush : rad;
			job_c_q     <= c_new;
			job_flush_q <= samples.last_in_line;
			job_short_q <= samples.last_in_line && (c_new < rad_c);
		end else if (job_vld_q && job_rdy) begin
			if (more_flush) begin
				job_m_q <= job_m_q - M_W'(1);
			end else begin
				job_vld_q <= 1'b0;
			end
		end
	end

	assign win                  = win_q;
	assign job_vld              = job_vld_q;
	assign job_m                = job_m_q;
	assign job_c                = job_c_q;
	assign job_flags.last       = job_flush_q && (job_m_q == '0);
	assign job_flags.line_short = job_short_q;

endmodule

// ===== hdl/mlf_tap_fetch.sv =====
// Mirrored tap fetch and pair pre-add, registered into stage 1
module mlf_tap_fetch import mlf_pkg::*; #(
	parameter int MAX_RADIUS   = 7,
	parameter int SAMPLE_WIDTH = 16,
	localparam int WIN   = 2 * MAX_RADIUS + 1,
	localparam int M_W   = $clog2(MAX_RADIUS + 1),
	localparam int CNT_W = $clog2(WIN + 1),
	localparam int IDX_W = $clog2(WIN)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [SAMPLE_WIDTH-1:0] win [WIN],
	input  logic [M_W-1:0]                 rad,
	input  logic                           antisym,
	input  logic                           job_vld,
	output logic                           job_rdy,
	input  logic [M_W-1:0]                 job_m,
	input  logic [CNT_W-1:0]               job_c,
	input  job_flags_t                     job_flags,
	output logic                           vld_s1,
	input  logic                           nxt_rdy,
	output logic signed [SAMPLE_WIDTH:0]   pair_s1 [MAX_RADIUS+1],
	output job_flags_t                     flags_s1
);

	localparam int D_W = CNT_W + 2;
	localparam logic signed [D_W-1:0] ONE_D = D_W'(1);

	logic signed [SAMPLE_WIDTH:0] pair_d [MAX_RADIUS+1];
	logic signed [D_W-1:0]        m_d;
	logic                         vld_s1_q;

	// reflect a distance into the held part of the line, edge repeated,
	// and clamp what still falls outside after one reflection
	function automatic logic [IDX_W-1:0] mirror_idx(
		input logic signed [D_W-1:0] d,
		input logic [CNT_W-1:0]      c
	);
		logic signed [D_W-1:0] cs;
		logic signed [D_W-1:0] r;
		cs = $signed(D_W'(c));
		if (d[D_W-1]) begin
			r = -d - ONE_D;
		end else if (d >= cs) begin
			r = (cs <<< 1) - ONE_D - d;
		end else begin
			r = d;
		end
		if (r[D_W-1]) begin
			r = '0;
		end
		if (r >= cs) begin
			r = cs - ONE_D;
		end
		return r[IDX_W-1:0];
	endfunction

	assign m_d = $signed(D_W'(job_m));

	// center tap
	assign pair_d[0] = (SAMPLE_WIDTH+1)'(win[mirror_idx(m_d, job_c)]);

	// side taps: newer sample paired with older one, unused taps zero
	for (genvar p = 1; p <= MAX_RADIUS; p++) begin : g_pair
		localparam logic signed [D_W-1:0] PD = D_W'(p);
		logic signed [SAMPLE_WIDTH:0] fwd;
		logic signed [SAMPLE_WIDTH:0] back;
		assign fwd  = (SAMPLE_WIDTH+1)'(win[mirror_idx(m_d - PD, job_c)]);
		assign back = (SAMPLE_WIDTH+1)'(win[mirror_idx(m_d + PD, job_c)]);
		assign pair_d[p] = (M_W'(p) > rad) ? '0 : (antisym ? fwd - back : fwd + back);
	end

	assign job_rdy = !vld_s1_q || nxt_rdy;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q <= 1'b0;
		end else if (job_rdy) begin
			vld_s1_q <= job_vld;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (job_rdy && job_vld) begin
			pair_s1  <= pair_d;
			flags_s1 <= job_flags;
		end
	end

	assign vld_s1 = vld_s1_q;

endmodule

// ===== hdl/mlf_mac.sv =====
// Coefficient multiply (stage 2), then sum, round and saturate into the result register
module mlf_mac import mlf_pkg::*; #(
	parameter int MAX_RADIUS     = 7,
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [COEF_W-1:0]     coef [MAX_RADIUS+1],
	input  logic                         vld_s1,
	output logic                         nxt_rdy,
	input  logic signed [SAMPLE_WIDTH:0] pair_s1 [MAX_RADIUS+1],
	input  job_flags_t                   flags_s1,
	mlf_out_if.source                    results
);

	localparam int PW     = SAMPLE_WIDTH + 1 + COEF_W;
	localparam int ACC_W  = PW + $clog2(MAX_RADIUS + 2) + 1;
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (SAMPLE_WIDTH - 1));

	logic signed [PW-1:0]    prod_s2 [MAX_RADIUS+1];
	job_flags_t              flags_s2;
	logic                    vld_s2_q;
	logic                    out_vld_q;
	logic                    out_adv;
	logic                    s2_adv;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] scaled;
	logic signed [SAMPLE_WIDTH-1:0] y_d;
	logic                    clip_d;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;
	logic                    clipped_q;
	job_flags_t              flags_q;

	assign out_adv = !out_vld_q || results.ready;
	assign s2_adv  = !vld_s2_q || out_adv;
	assign nxt_rdy = s2_adv;

	// valid bits of stage 2 and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s2_adv) begin
				vld_s2_q <= vld_s1;
			end
			if (out_adv) begin
				out_vld_q <= vld_s2_q;
			end
		end
	end

	// stage 2: one product per tap
	always_ff @(posedge clk) begin
		if (s2_adv && vld_s1) begin
			for (int p = 0; p <= MAX_RADIUS; p++) begin
				prod_s2[p] <= pair_s1[p] * coef[p];
			end
			flags_s2 <= flags_s1;
		end
	end

	// product sum, round half up, saturate
	always_comb begin
		acc = '0;
		for (int p = 0; p <= MAX_RADIUS; p++) begin
			acc = acc + ACC_W'(prod_s2[p]);
		end
		scaled = (acc + RND) >>> COEF_FRAC_BITS;
		if (scaled > SAT_HI) begin
			y_d    = SAT_HI[SAMPLE_WIDTH-1:0];
			clip_d = 1'b1;
		end else if (scaled < SAT_LO) begin
			y_d    = SAT_LO[SAMPLE_WIDTH-1:0];
			clip_d = 1'b1;
		end else begin
			y_d    = scaled[SAMPLE_WIDTH-1:0];
			clip_d = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_adv && vld_s2_q) begin
			filtered_q <= y_d;
			clipped_q  <= clip_d;
			flags_q    <= flags_s2;
		end
	end

	assign results.valid          = out_vld_q;
	assign results.filtered       = filtered_q;
	assign results.clipped        = clipped_q;
	assign results.last_of_line   = flags_q.last;
	assign results.line_too_short = flags_q.line_short;

endmodule

// ===== hdl/mirrored_line_fir_sym_antisym_unit.sv =====
// Top level of the mirrored-boundary symmetric/antisymmetric line filter
// Path: window and job register, stage 1, stage 2, then the result register.
// Throughput: one sample per cycle unless stalled; a line end releases min(radius, held - 1) + 1
// results, one per ready cycle from the position sequencer; input waits until the last one issues.
// Reset: arst_n clears line count, pipeline valids and registers (c0 = 1.0, radius 1, symmetric).
`include "mirrored_line_fir_sym_antisym_unit_assert.svh"
module mirrored_line_fir_sym_antisym_unit import mlf_pkg::*; #(
	parameter int MAX_RADIUS     = 7,
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	mlf_in_if.sink            samples,
	mlf_out_if.source         results
);

	localparam int WIN   = 2 * MAX_RADIUS + 1;
	localparam int M_W   = $clog2(MAX_RADIUS + 1);
	localparam int CNT_W = $clog2(WIN + 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [COEF_W-1:0]       coef [MAX_RADIUS+1];
	logic [M_W-1:0]                 rad;
	logic                           antisym;
	logic signed [SAMPLE_WIDTH-1:0] win [WIN];
	logic                           job_vld;
	logic                           job_rdy;
	logic [M_W-1:0]                 job_m;
	logic [CNT_W-1:0]               job_c;
	job_flags_t                     job_flags;
	logic                           vld_s1;
	logic                           nxt_rdy;
	logic signed [SAMPLE_WIDTH:0]   pair_s1 [MAX_RADIUS+1];
	job_flags_t                     flags_s1;
	logic                           line_end_take;
	logic                           on_rail;

	mlf_cfg_regs #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef),
		.rad     (rad),
		.antisym (antisym)
	);

	mlf_window #(
		.MAX_RADIUS   (MAX_RADIUS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.rad       (rad),
		.win       (win),
		.job_vld   (job_vld),
		.job_rdy   (job_rdy),
		.job_m     (job_m),
		.job_c     (job_c),
		.job_flags (job_flags)
	);

	mlf_tap_fetch #(
		.MAX_RADIUS   (MAX_RADIUS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win),
		.rad       (rad),
		.antisym   (antisym),
		.job_vld   (job_vld),
		.job_rdy   (job_rdy),
		.job_m     (job_m),
		.job_c     (job_c),
		.job_flags (job_flags),
		.vld_s1    (vld_s1),
		.nxt_rdy   (nxt_rdy),
		.pair_s1   (pair_s1),
		.flags_s1  (flags_s1)
	);

	mlf_mac #(
		.MAX_RADIUS     (MAX_RADIUS),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.vld_s1   (vld_s1),
		.nxt_rdy  (nxt_rdy),
		.pair_s1  (pair_s1),
		.flags_s1 (flags_s1),
		.results  (results)
	);

	// terms used by the checks below
	assign line_end_take = samples.valid && samples.ready && samples.last_in_line;
	assign on_rail       = (results.filtered == OUT_HI) || (results.filtered == OUT_LO);

	// a pending position that cannot move on must hold off new samples
	`MLF_ASSERT_IMP(a_stall_blocks_input, job_vld && !job_rdy, !samples.ready)
	// a line end always leaves at least one position to issue
	`MLF_ASSERT_NEXT(a_line_end_issues, line_end_take, job_vld)
	// a clipped result sits on one of the rails
	`MLF_ASSERT_IMP(a_clip_on_rail, results.valid && results.clipped, on_rail)

endmodule
